// ===== src/pcc_pkg.sv =====
// pcc_pkg: shared constants, step codes and controller/datapath interface structs
// for the pearson correlation block; no dependencies
package pcc_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int MaxPairsDefault   = 1048576;

   localparam logic [15:0]    CandMax = 16'd32768;
   localparam logic [15:0]    OutMax  = 16'd32767;
   localparam logic [3:0]     BitTop  = 4'd15;

   typedef enum logic [3:0] {
      STEP_NSXY,
      STEP_SXSY,
      STEP_NSXX,
      STEP_SXSX,
      STEP_NSYY,
      STEP_SYSY,
      STEP_PROD,
      STEP_SQ,
      STEP_TEST
   } step_type;

   typedef struct packed {
      logic       accum;
      logic       clear;
      logic       mul_start;
      step_type   step;
      logic       prep;
      logic       m_clear;
      logic [3:0] bit_idx;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic var_zero;
      logic cand_skip;
   } status_type;

endpackage

// ===== src/pearson_correlation_top.sv =====
// pearson_correlation_top: streaming pearson correlation of signed sample pairs
// depends on pcc_pkg, pcc_ctrl, pcc_datapath
//
// requests carry a sample pair and a last flag; one request is taken per cycle
// while the block accumulates, so a series streams at full rate.
// a request marked last is accumulated and then closes the series: the finish
// runs eight products and a 16-step rounding search on one shift-add multiplier
// that retires one multiplier bit per cycle; its multiplier operand is BW bits,
// with BW = max(NW, 32) and NW = 2*SW + 2*CW + 2.
// requests are stalled during the finish.
// one response follows each last request: Q1.15 correlation with +1 saturated
// and a degenerate flag when either variance is zero.
// the response sits in an output register; while it is stalled the block keeps
// taking requests of the next series, and a second finish holds until it is taken.
// reset clears the sums and the count and drops rsp_valid; pairs past the
// maximum count are not accumulated.
module pearson_correlation_top #(
   parameter int SAMPLE_BITS = pcc_pkg::SampleBitsDefault,
   parameter int MAX_PAIRS   = pcc_pkg::MaxPairsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_correlation,
   output logic               rsp_degenerate
);
   import pcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pcc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd)
   );

   pcc_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_PAIRS(MAX_PAIRS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .cmd             (cmd),
      .status          (status),
      .rsp_correlation (rsp_correlation),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule

// ===== src/pcc_mul.sv =====
// pcc_mul: shift-add multiplier, one bit of b per cycle, sign applied at the end
// depends on nothing
module pcc_mul #(
   parameter int AW = 152,
   parameter int BW = 76
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [AW-1:0]           a,
   input  logic [BW-1:0]           b,
   input  logic                    neg,
   output logic                    done,
   output logic signed [AW+BW-1:0] product
);
   localparam int PW   = AW + BW;
   localparam int CNTW = $clog2(BW + 1);

   logic [PW-1:0]   acc_ff, acc_in, ash_ff, ash_in;
   logic [BW-1:0]   bsh_ff, bsh_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, fix_ff, fix_in, done_ff, done_in, neg_ff, neg_in;

   always_comb begin
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      bsh_in  = bsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      if (start) begin
         acc_in  = '0;
         ash_in  = PW'(a);
         bsh_in  = b;
         cnt_in  = CNTW'(BW);
         busy_in = 1'b1;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (bsh_ff[0]) begin
            acc_in = acc_ff + ash_ff;
         end
         ash_in = ash_ff << 1;
         bsh_in = bsh_ff >> 1;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         acc_in  = neg_ff ? (~acc_ff + PW'(1)) : acc_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = signed'(acc_ff);

endmodule

// ===== src/pcc_datapath.sv =====
// pcc_datapath: running sums, wide finish registers, rounding search and output regs
// depends on pcc_pkg and pcc_mul
module pcc_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_PAIRS   = 1048576
) (
   input  logic                clock,
   input  logic                reset,
   input  logic signed [15:0]  req_sample_x,
   input  logic signed [15:0]  req_sample_y,
   input  pcc_pkg::cmd_type    cmd,
   output pcc_pkg::status_type status,
   output logic signed [15:0]  rsp_correlation,
   output logic                rsp_degenerate
);
   import pcc_pkg::*;

   localparam int SW   = (SAMPLE_BITS > 16) ? 17 : SAMPLE_BITS;
   localparam int CW   = $clog2(MAX_PAIRS + 1);
   localparam int SUMW = SW + CW;
   localparam int SQW  = 2 * SW + CW;
   localparam int NW   = 2 * SW + 2 * CW + 2;
   localparam int AW   = 2 * NW;
   localparam int BW   = (NW > 32) ? NW : 32;
   localparam int PW   = AW + BW;
   localparam int LW   = AW + 32;

   logic signed [SW-1:0]   xs, ys;
   logic signed [2*SW-1:0] xx, yy, xy;

   if (SAMPLE_BITS > 16) begin : g_wide
      assign xs = signed'(SW'({1'b0, req_sample_x}));
      assign ys = signed'(SW'({1'b0, req_sample_y}));
   end else begin : g_narrow
      assign xs = signed'(req_sample_x[SW-1:0]);
      assign ys = signed'(req_sample_y[SW-1:0]);
   end

   assign xx = xs * xs;
   assign yy = ys * ys;
   assign xy = xs * ys;

   logic [CW-1:0]          cnt_ff;
   logic signed [SUMW-1:0] sx_ff, sy_ff;
   logic signed [SQW-1:0]  sxx_ff, syy_ff, sxy_ff;
   logic                   full;

   assign full = (cnt_ff == CW'(MAX_PAIRS));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (cmd.accum && !full) begin
         cnt_ff <= cnt_ff + CW'(1);
         sx_ff  <= sx_ff + SUMW'(xs);
         sy_ff  <= sy_ff + SUMW'(ys);
         sxx_ff <= sxx_ff + SQW'(xx);
         syy_ff <= syy_ff + SQW'(yy);
         sxy_ff <= sxy_ff + SQW'(xy);
      end
   end

   logic signed [NW-1:0] n_w, sx_w, sy_w, sxx_w, syy_w, sxy_w;
   logic signed [NW-1:0] tmp_ff, num_ff, vx_ff, vy_ff;
   logic [AW-1:0]        prod_ff;
   logic [LW-1:0]        lim_ff;
   logic [15:0]          m_ff, cand_ff, cand;
   logic [15:0]          d_w;
   logic [31:0]          d2_ff;
   logic signed [NW-1:0] oa, ob;
   logic [NW-1:0]        a_mag, b_mag;
   logic [AW-1:0]        mul_a;
   logic [BW-1:0]        mul_b;
   logic                 mul_neg, mul_done;
   logic signed [PW-1:0] p;
   logic [PW-1:0]        p_u;
   logic signed [15:0]   corr_ff;
   logic                 deg_ff;
   logic [15:0]          m_sat;

   assign n_w   = signed'(NW'(cnt_ff));
   assign sx_w  = NW'(sx_ff);
   assign sy_w  = NW'(sy_ff);
   assign sxx_w = NW'(sxx_ff);
   assign syy_w = NW'(syy_ff);
   assign sxy_w = NW'(sxy_ff);

   always_comb begin
      case (cmd.step)
         STEP_NSXY: begin oa = n_w;    ob = sxy_w;  end
         STEP_SXSY: begin oa = sx_w;   ob = sy_w;   end
         STEP_NSXX: begin oa = n_w;    ob = sxx_w;  end
         STEP_SXSX: begin oa = sx_w;   ob = sx_w;   end
         STEP_NSYY: begin oa = n_w;    ob = syy_w;  end
         STEP_SYSY: begin oa = sy_w;   ob = sy_w;   end
         STEP_PROD: begin oa = vx_ff;  ob = vy_ff;  end
         STEP_SQ:   begin oa = num_ff; ob = num_ff; end
         default:   begin oa = '0;     ob = '0;     end
      endcase
      a_mag = oa[NW-1] ? unsigned'(-oa) : unsigned'(oa);
      b_mag = ob[NW-1] ? unsigned'(-ob) : unsigned'(ob);
      if (cmd.step == STEP_TEST) begin
         mul_a   = prod_ff;
         mul_b   = BW'(d2_ff);
         mul_neg = 1'b0;
      end else begin
         mul_a   = AW'(a_mag);
         mul_b   = BW'(b_mag);
         mul_neg = oa[NW-1] ^ ob[NW-1];
      end
   end

   pcc_mul #(.AW(AW), .BW(BW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .neg     (mul_neg),
      .done    (mul_done),
      .product (p)
   );

   assign p_u  = unsigned'(p);
   assign cand = m_ff | (16'd1 << cmd.bit_idx);
   assign d_w  = 16'({cand, 1'b0} - 17'd1);
   assign m_sat = (m_ff > OutMax) ? OutMax : m_ff;

   always_ff @(posedge clock) begin
      if (mul_done) begin
         case (cmd.step)
            STEP_NSXY, STEP_NSXX, STEP_NSYY: tmp_ff <= signed'(p[NW-1:0]);
            STEP_SXSY: num_ff  <= tmp_ff - signed'(p[NW-1:0]);
            STEP_SXSX: vx_ff   <= tmp_ff - signed'(p[NW-1:0]);
            STEP_SYSY: vy_ff   <= tmp_ff - signed'(p[NW-1:0]);
            STEP_PROD: prod_ff <= p_u[AW-1:0];
            STEP_SQ:   lim_ff  <= {p_u[AW-1:0], 32'd0};
            STEP_TEST: begin
               if (p_u <= PW'(lim_ff)) begin
                  m_ff <= cand_ff;
               end
            end
            default: tmp_ff <= tmp_ff;
         endcase
      end
      if (cmd.m_clear) begin
         m_ff <= '0;
      end
      if (cmd.prep) begin
         cand_ff <= cand;
         d2_ff   <= d_w * d_w;
      end
      if (cmd.out_load) begin
         deg_ff <= status.var_zero;
         if (status.var_zero) begin
            corr_ff <= '0;
         end else if (num_ff[NW-1]) begin
            corr_ff <= signed'(16'(~m_ff + 16'd1));
         end else begin
            corr_ff <= signed'(m_sat);
         end
      end
   end

   assign status.mul_done  = mul_done;
   assign status.var_zero  = (vx_ff == '0) || vx_ff[NW-1] || (vy_ff == '0) || vy_ff[NW-1];
   assign status.cand_skip = (cand_ff > CandMax);

   assign rsp_correlation = corr_ff;
   assign rsp_degenerate  = deg_ff;

endmodule

// ===== src/pcc_ctrl.sv =====
// pcc_ctrl: sequencer for accumulation, the finish multiplications and the result handshake
// depends on pcc_pkg
module pcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_sample,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pcc_pkg::status_type status,
   output pcc_pkg::cmd_type    cmd
);
   import pcc_pkg::*;

   typedef enum logic [2:0] {
      S_ACC, S_ISSUE, S_WAIT, S_CHECK, S_PREP, S_SKIP, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   step_type   step_ff, step_in;
   logic [3:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       held;

   assign held = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      rsp_valid_in = held;
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.bit_idx  = bit_ff;
      case (state_ff)
         S_ACC: begin
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (req_last_sample) begin
                  step_in  = STEP_NSXY;
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            cmd.mul_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.mul_done) begin
               case (step_ff)
                  STEP_SYSY: state_in = S_CHECK;
                  STEP_SQ: begin
                     cmd.m_clear = 1'b1;
                     bit_in      = BitTop;
                     state_in    = S_PREP;
                  end
                  STEP_TEST: begin
                     if (bit_ff == 4'd0) begin
                        state_in = S_DONE;
                     end else begin
                        bit_in   = bit_ff - 4'd1;
                        state_in = S_PREP;
                     end
                  end
                  default: begin
                     step_in  = step_type'(4'(step_ff) + 4'd1);
                     state_in = S_ISSUE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (status.var_zero) begin
               state_in = S_DONE;
            end else begin
               step_in  = STEP_PROD;
               state_in = S_ISSUE;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SKIP;
         end
         S_SKIP: begin
            if (status.cand_skip) begin
               if (bit_ff == 4'd0) begin
                  state_in = S_DONE;
               end else begin
                  bit_in   = bit_ff - 4'd1;
                  state_in = S_PREP;
               end
            end else begin
               step_in  = STEP_TEST;
               state_in = S_ISSUE;
            end
         end
         S_DONE: begin
            if (!held) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      bit_ff  <= bit_in;
      if (reset) begin
         state_ff     <= S_ACC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_ACC);
   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a held response");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_sample) |=> (state_ff == S_ISSUE))
      else $error("last request did not start the finish");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == S_WAIT))
      else $error("multiplier finished outside wait state");

endmodule
